// File: src/vpvs_pkg.sv
package vpvs_pkg;

    // fixed field widths
    localparam int IDX_W   = 10;
    localparam int POS_W   = 16;
    localparam int STR_W   = 16;
    localparam int VEL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int SIG_W   = 20;
    localparam int CFG_W   = 20;
    localparam int ENTRY_W = 2 * POS_W + STR_W;

    localparam int MAX_PARTICLES_DEF = 1024;

    // datapath widths
    localparam int R2_W   = 33;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIVD_W = 64;
    localparam int DIVS_W = 50;
    localparam int ACC_W  = 52;
    localparam int K_W    = 4;

    localparam logic [SIG_W-1:0] SIGMA_SQ_RST = 20'd1049;
    localparam logic [R2_W-1:0]  EPS_Q28      = 33'd268;
    localparam logic [MUL_W-1:0] TWO_PI_Q14   = 34'd102944;
    localparam logic [32:0]      ONE_Q32      = 33'h1_0000_0000;
    localparam logic [MUL_W-1:0] TWO_Q32      = 34'h2_0000_0000;
    localparam logic [K_W-1:0]   K_FIRST      = 4'd12;
    localparam logic [K_W-1:0]   K_LAST       = 4'd2;
    localparam logic [2:0]       DBL_LAST     = 3'd5;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

    typedef enum logic {
        CFG_PARTICLE_COUNT,
        CFG_SIGMA_SQ
    } cfg_idx_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_QLATCH,
        DP_DIFF,
        DP_SQX,
        DP_SQY,
        DP_R2,
        DP_YDIV,
        DP_YCHK,
        DP_HMUL,
        DP_HRCP,
        DP_HCORR,
        DP_GMUL,
        DP_GWB,
        DP_DMUL,
        DP_DENMUL,
        DP_DENWB,
        DP_NXMUL,
        DP_NYMUL,
        DP_NGMUL,
        DP_TXDIV,
        DP_TYDIV,
        DP_ACCX,
        DP_ACCY,
        DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_R2,
        ST_ZCHK,
        ST_YWAIT,
        ST_YCHK,
        ST_HMUL,
        ST_HRCP,
        ST_HCORR,
        ST_GMUL,
        ST_GWB,
        ST_DMUL,
        ST_DWB,
        ST_DENMUL,
        ST_DENWB,
        ST_NXMUL,
        ST_NXG,
        ST_TXGO,
        ST_TXWAIT,
        ST_ACCX,
        ST_NYMUL,
        ST_NYG,
        ST_TYGO,
        ST_TYWAIT,
        ST_ACCY,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        dp_op_t         op;
        logic [K_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic r2_zero;
        logic y_big;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // floor(2^32 / k) for the horner divisions
    function automatic logic [31:0] recip(input logic [K_W-1:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/vpvs_if.sv
interface vpvs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [vpvs_pkg::IDX_W-1:0]     index;
    logic signed [vpvs_pkg::POS_W-1:0] pos_x;
    logic signed [vpvs_pkg::POS_W-1:0] pos_y;
    logic signed [vpvs_pkg::STR_W-1:0] strength;

    modport source (output valid, operation, index, pos_x, pos_y, strength, input ready);
    modport sink   (input valid, operation, index, pos_x, pos_y, strength, output ready);
endinterface

interface vpvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vpvs_pkg::VEL_W-1:0] vel_x;
    logic signed [vpvs_pkg::VEL_W-1:0] vel_y;
    logic                              saturated;

    modport source (output valid, vel_x, vel_y, saturated, input ready);
    modport sink   (input valid, vel_x, vel_y, saturated, output ready);
endinterface

// File: src/vpvs_div.sv
module vpvs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vpvs_pkg::DIVD_W-1:0]   dividend,
    input  logic [vpvs_pkg::DIVS_W-1:0]   divisor,
    output logic                          busy,
    output logic [vpvs_pkg::DIVD_W-1:0]   quotient
);
    import vpvs_pkg::*;

    localparam logic [6:0] STEPS = 7'(DIVD_W);

    logic              busy_reg;
    logic [6:0]        cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;
    logic [DIVS_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? DIVS_W'(trial - {1'b0, dsr_reg}) : trial[DIVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: src/vpvs_datapath.sv
module vpvs_datapath #(
    parameter  int MAX_PARTICLES = vpvs_pkg::MAX_PARTICLES_DEF,
    localparam int AddrW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vpvs_pkg::dp_cmd_t                   cmd,
    input  logic [AddrW-1:0]                    rd_addr,
    output vpvs_pkg::dp_status_t                status,
    input  logic [vpvs_pkg::IDX_W-1:0]          index,
    input  logic [vpvs_pkg::POS_W-1:0]          pos_x,
    input  logic [vpvs_pkg::POS_W-1:0]          pos_y,
    input  logic [vpvs_pkg::STR_W-1:0]          strength,
    input  logic [vpvs_pkg::SIG_W-1:0]          sigma_sq,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vpvs_pkg::VEL_W-1:0]          vel_x,
    output logic [vpvs_pkg::VEL_W-1:0]          vel_y,
    output logic                                saturated
);
    import vpvs_pkg::*;

    // particle store
    logic [ENTRY_W-1:0] mem [MAX_PARTICLES];
    logic [ENTRY_W-1:0] rd_reg;
    logic [AddrW-1:0]   wr_addr;
    logic               load_ok;

    assign wr_addr = AddrW'(index);
    assign load_ok = 32'(index) < MAX_PARTICLES;

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD && load_ok)
            mem[wr_addr] <= {pos_x, pos_y, strength};
        rd_reg <= mem[rd_addr];
    end

    logic [POS_W-1:0] ent_x, ent_y;
    logic [STR_W-1:0] ent_s;
    assign {ent_x, ent_y, ent_s} = rd_reg;

    logic [POS_W-1:0]  px_reg, py_reg;
    logic [15:0]       ax_reg, ay_reg, sabs_reg;
    logic              sxn_reg, syn_reg, ssn_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [30:0]       y_reg;
    logic [32:0]       t_reg, g_reg;
    logic [31:0]       v_reg;
    logic [DIVS_W-1:0] den_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  accx_reg, accy_reg;
    logic              out_valid_reg;
    logic [VEL_W-1:0]  velx_reg, vely_reg;
    logic              sat_reg;

    // differences, q3.14
    logic [16:0] rx, ry;
    assign rx = {px_reg[POS_W-1], px_reg} - {ent_x[POS_W-1], ent_x};
    assign ry = {py_reg[POS_W-1], py_reg} - {ent_y[POS_W-1], ent_y};

    // shared multiplier
    logic [MUL_W-1:0] mul_a, mul_b;
    logic             mul_en;
    logic [R2_W-1:0]  d_clamp;

    assign d_clamp = (r2_reg > EPS_Q28) ? r2_reg : EPS_Q28;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            DP_SQX:
            begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            DP_SQY:
            begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
            end
            DP_HMUL, DP_GMUL:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(t_reg);
            end
            DP_HRCP:
            begin
                mul_a = MUL_W'(prod_reg[63:32]);
                mul_b = MUL_W'(recip(cmd.k));
            end
            DP_DMUL:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = TWO_Q32 - MUL_W'(g_reg);
            end
            DP_DENMUL:
            begin
                mul_a = MUL_W'(d_clamp);
                mul_b = TWO_PI_Q14;
            end
            DP_NXMUL:
            begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(sabs_reg);
            end
            DP_NYMUL:
            begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(sabs_reg);
            end
            DP_NGMUL:
            begin
                mul_a = MUL_W'(prod_reg[31:0]);
                mul_b = MUL_W'(g_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // divider
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_busy;
    logic [DIVD_W-1:0] quo;
    logic [SIG_W-1:0]  s2;

    assign s2 = (sigma_sq == '0) ? SIG_W'(1) : sigma_sq;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = prod_reg[DIVD_W-1:0];
        div_divisor  = den_reg;
        case (cmd.op)
            DP_YDIV:
            begin
                div_start    = 1'b1;
                div_dividend = {14'd0, r2_reg, 17'd0};
                div_divisor  = DIVS_W'(s2);
            end
            DP_TXDIV, DP_TYDIV: div_start = 1'b1;
            default: div_start = 1'b0;
        endcase
    end

    vpvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    // horner step correction: q = floor(v / k)
    logic [31:0] q0, q_fix;
    logic [35:0] q0k, rem_k;
    assign q0    = prod_reg[63:32];
    assign q0k   = 36'(q0) * 36'(cmd.k);
    assign rem_k = {4'd0, v_reg} - q0k;
    assign q_fix = (rem_k >= 36'(cmd.k)) ? q0 + 32'd1 : q0;

    logic [ACC_W-1:0] term;
    assign term = quo[ACC_W-1:0];

    // saturation
    logic        clip_x, clip_y;
    logic [31:0] satx, saty;
    always_comb
    begin
        clip_x = !((accx_reg[ACC_W-1:31] == '0) || (accx_reg[ACC_W-1:31] == '1));
        clip_y = !((accy_reg[ACC_W-1:31] == '0) || (accy_reg[ACC_W-1:31] == '1));
        satx = clip_x ? (accx_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      : accx_reg[31:0];
        saty = clip_y ? (accy_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      : accy_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_QLATCH:
            begin
                px_reg   <= pos_x;
                py_reg   <= pos_y;
                accx_reg <= '0;
                accy_reg <= '0;
            end
            DP_DIFF:
            begin
                ax_reg   <= rx[16] ? 16'(~rx + 17'd1) : rx[15:0];
                ay_reg   <= ry[16] ? 16'(~ry + 17'd1) : ry[15:0];
                sxn_reg  <= rx[16];
                syn_reg  <= ry[16];
                sabs_reg <= ent_s[STR_W-1] ? (~ent_s + 16'd1) : ent_s;
                ssn_reg  <= ent_s[STR_W-1];
            end
            DP_SQY:   r2_reg <= prod_reg[R2_W-1:0];
            DP_R2:    r2_reg <= r2_reg + prod_reg[R2_W-1:0];
            DP_YCHK:
            begin
                y_reg <= quo[30:0];
                t_reg <= ONE_Q32;
                if (status.y_big)
                    g_reg <= ONE_Q32;
            end
            DP_HRCP:  v_reg <= prod_reg[63:32];
            DP_HCORR: t_reg <= ONE_Q32 - {1'b0, q_fix};
            DP_GWB:   g_reg <= prod_reg[64:32];
            DP_DENWB: den_reg <= prod_reg[DIVS_W-1:0];
            DP_ACCX:  accx_reg <= (syn_reg ^ ssn_reg) ? accx_reg - term : accx_reg + term;
            DP_ACCY:  accy_reg <= (sxn_reg ^ ssn_reg) ? accy_reg + term : accy_reg - term;
            DP_OUT:
            begin
                velx_reg <= satx;
                vely_reg <= saty;
                sat_reg  <= clip_x | clip_y;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.r2_zero  = (r2_reg == '0);
    assign status.y_big    = |quo[DIVD_W-1:31];
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign vel_x     = velx_reg;
    assign vel_y     = vely_reg;
    assign saturated = sat_reg;

endmodule

// File: src/vpvs_ctrl.sv
module vpvs_ctrl #(
    parameter  int MAX_PARTICLES = vpvs_pkg::MAX_PARTICLES_DEF,
    localparam int AddrW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [vpvs_pkg::CNT_W-1:0]     particle_count,
    input  vpvs_pkg::dp_status_t           status,
    output vpvs_pkg::dp_cmd_t              cmd,
    output logic [AddrW-1:0]               rd_addr
);
    import vpvs_pkg::*;

    localparam int CntW = $clog2(MAX_PARTICLES + 1);

    state_t           state_reg, state_next;
    logic [CntW-1:0]  i_reg, i_next;
    logic [CntW-1:0]  n_reg, n_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [2:0]       dbl_reg, dbl_next;
    logic [CntW-1:0]  n_clamp;

    assign n_clamp = (32'(particle_count) > MAX_PARTICLES) ? CntW'(MAX_PARTICLES)
                                                           : CntW'(particle_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            dbl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            dbl_reg   <= dbl_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        dbl_next   = dbl_reg;
        cmd.op     = DP_NOP;
        cmd.k      = k_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.op     = DP_QLATCH;
                        n_next     = n_clamp;
                        i_next     = '0;
                        state_next = ST_START;
                    end
                    else
                        cmd.op = DP_LOAD;
                end
            end
            ST_START:  state_next = (n_reg == '0) ? ST_DONE : ST_READ;
            ST_READ:   state_next = ST_DIFF;
            ST_DIFF:
            begin
                cmd.op     = DP_DIFF;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                cmd.op     = DP_SQX;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.op     = DP_SQY;
                state_next = ST_R2;
            end
            ST_R2:
            begin
                cmd.op     = DP_R2;
                state_next = ST_ZCHK;
            end
            ST_ZCHK:
            begin
                // coincident particle contributes nothing
                if (status.r2_zero)
                    state_next = ST_NEXT;
                else
                begin
                    cmd.op     = DP_YDIV;
                    state_next = ST_YWAIT;
                end
            end
            ST_YWAIT:  if (!status.div_busy) state_next = ST_YCHK;
            ST_YCHK:
            begin
                cmd.op     = DP_YCHK;
                k_next     = K_FIRST;
                dbl_next   = '0;
                state_next = status.y_big ? ST_DENMUL : ST_HMUL;
            end
            ST_HMUL:
            begin
                cmd.op     = DP_HMUL;
                state_next = ST_HRCP;
            end
            ST_HRCP:
            begin
                cmd.op     = DP_HRCP;
                state_next = ST_HCORR;
            end
            ST_HCORR:
            begin
                cmd.op     = DP_HCORR;
                k_next     = k_reg - 4'd1;
                state_next = (k_reg == K_LAST) ? ST_GMUL : ST_HMUL;
            end
            ST_GMUL:
            begin
                cmd.op     = DP_GMUL;
                state_next = ST_GWB;
            end
            ST_GWB:
            begin
                cmd.op     = DP_GWB;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.op     = DP_DMUL;
                state_next = ST_DWB;
            end
            ST_DWB:
            begin
                cmd.op     = DP_GWB;
                dbl_next   = dbl_reg + 3'd1;
                state_next = (dbl_reg == DBL_LAST) ? ST_DENMUL : ST_DMUL;
            end
            ST_DENMUL:
            begin
                cmd.op     = DP_DENMUL;
                state_next = ST_DENWB;
            end
            ST_DENWB:
            begin
                cmd.op     = DP_DENWB;
                state_next = ST_NXMUL;
            end
            ST_NXMUL:
            begin
                cmd.op     = DP_NXMUL;
                state_next = ST_NXG;
            end
            ST_NXG:
            begin
                cmd.op     = DP_NGMUL;
                state_next = ST_TXGO;
            end
            ST_TXGO:
            begin
                cmd.op     = DP_TXDIV;
                state_next = ST_TXWAIT;
            end
            ST_TXWAIT: if (!status.div_busy) state_next = ST_ACCX;
            ST_ACCX:
            begin
                cmd.op     = DP_ACCX;
                state_next = ST_NYMUL;
            end
            ST_NYMUL:
            begin
                cmd.op     = DP_NYMUL;
                state_next = ST_NYG;
            end
            ST_NYG:
            begin
                cmd.op     = DP_NGMUL;
                state_next = ST_TYGO;
            end
            ST_TYGO:
            begin
                cmd.op     = DP_TYDIV;
                state_next = ST_TYWAIT;
            end
            ST_TYWAIT: if (!status.div_busy) state_next = ST_ACCY;
            ST_ACCY:
            begin
                cmd.op     = DP_ACCY;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                i_next     = i_reg + CntW'(1);
                state_next = (i_next == n_reg) ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign rd_addr = i_reg[AddrW-1:0];

endmodule

// File: src/vortex_particle_velocity_sum.sv
// channel    | dir | payload                                      | transaction
// -----------+-----+----------------------------------------------+---------------------
// in_item    | in  | operation, index, pos_x, pos_y, strength     | valid & ready
// out_item   | out | vel_x, vel_y, saturated                      | valid & ready
// cfg        | in  | cfg_index, cfg_data                          | cfg_we
//
// a load is written to the store when accepted; a query walks the n stored particles
// (a saturated kernel skips horner and doublings; a coincident particle is skipped)
// the per-particle time is set by three 64-step passes through the shared radix-2
// divider plus eleven horner steps and six doublings on the shared multiplier
// rst_n clears control and configuration; the particle store is not cleared
// a finished result waits in the output register; loads are still taken meanwhile
module vortex_particle_velocity_sum #(
    parameter int MAX_PARTICLES = vpvs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  vpvs_pkg::cfg_idx_t             cfg_index,
    input  logic [vpvs_pkg::CFG_W-1:0]     cfg_data,
    vpvs_in_if.sink                        in_item,
    vpvs_out_if.source                     out_item
);
    import vpvs_pkg::*;

    localparam int AddrW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // configuration registers
    logic [CNT_W-1:0] count_reg;
    logic [SIG_W-1:0] sigma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sigma_reg <= SIGMA_SQ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PARTICLE_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                CFG_SIGMA_SQ:       sigma_reg <= cfg_data[SIG_W-1:0];
                default:            ;
            endcase
        end
    end

    // controller / datapath link
    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [AddrW-1:0] rd_addr;

    vpvs_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_item.valid),
        .in_ready       (in_item.ready),
        .operation      (in_item.operation),
        .particle_count (count_reg),
        .status         (status),
        .cmd            (cmd),
        .rd_addr        (rd_addr)
    );

    vpvs_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .status    (status),
        .index     (in_item.index),
        .pos_x     (in_item.pos_x),
        .pos_y     (in_item.pos_y),
        .strength  (in_item.strength),
        .sigma_sq  (sigma_reg),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .vel_x     (out_item.vel_x),
        .vel_y     (out_item.vel_y),
        .saturated (out_item.saturated)
    );

endmodule

// File: src/vpvs_checker.sv
module vpvs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_operation,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [vpvs_pkg::VEL_W-1:0]   vel_x,
    input logic [vpvs_pkg::VEL_W-1:0]   vel_y,
    input logic                         saturated
);
    import vpvs_pkg::*;

    // a query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_operation == OP_QUERY |=> !in_ready)
        else $error("input still ready after query transaction");

    // results only come out of a running query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a query in progress");

    // loads never make results
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_operation == OP_LOAD && !out_valid |=> !out_valid)
        else $error("load transaction produced a result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vel_x) && $stable(vel_y) && $stable(saturated))
        else $error("result changed while stalled");

endmodule

bind vortex_particle_velocity_sum vpvs_checker u_vpvs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_item.valid),
    .in_ready     (in_item.ready),
    .in_operation (in_item.operation),
    .out_valid    (out_item.valid),
    .out_ready    (out_item.ready),
    .vel_x        (out_item.vel_x),
    .vel_y        (out_item.vel_y),
    .saturated    (out_item.saturated)
);

// File: bench/tb_vortex_particle_velocity_sum.sv
`timescale 1ns / 1ps

module tb_vortex_particle_velocity_sum;
    import vpvs_pkg::*;

    localparam int           NUM_ENTRIES = 1024;
    localparam longint       CYCLE_LIMIT = 20000000;
    localparam int           SETTLE      = 40;
    localparam int           HOLD_CYCLES = 4000;
    localparam longint unsigned UNITY    = 64'h1_0000_0000;

    typedef struct {
        op_t                 op;
        logic [IDX_W-1:0]    index;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic signed [15:0]  strength;
    } item_t;

    typedef struct {
        logic signed [31:0]  vel_x;
        logic signed [31:0]  vel_y;
        logic                saturated;
    } vel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    vpvs_in_if  in_bus ();
    vpvs_out_if out_bus ();

    vortex_particle_velocity_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_bus),
        .out_item  (out_bus)
    );

    // predictor state: particle store and register copies
    logic signed [15:0] part_x [NUM_ENTRIES];
    logic signed [15:0] part_y [NUM_ENTRIES];
    logic signed [15:0] part_s [NUM_ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [SIG_W-1:0]   sigma_reg;

    // stimulus bookkeeping
    item_t  pending_items [$];
    vel_t   expected_vel [$];
    bit     written [NUM_ENTRIES];
    int     errors;
    bit     quiet;
    bit     hold_start;
    int     hold_left;
    int     in_gap;
    int     out_gap;
    longint cycles = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // 1 - exp(-r2 / (2 sigma)) in Q1.32, horner series plus six doublings
    function automatic longint unsigned kernel_gain(longint unsigned r2, longint unsigned s2);
        longint unsigned y;
        longint unsigned t;
        longint unsigned g;
        y = (r2 << 17) / s2;
        if (y >= 64'h8000_0000)
            return UNITY;
        t = UNITY;
        for (int k = 12; k >= 2; k--)
            t = UNITY - ((y * t) >> 32) / longint'(k);
        g = (y * t) >> 32;
        for (int k = 0; k < 6; k++)
            g = (g * ((UNITY << 1) - g)) >> 32;
        return g;
    endfunction

    function automatic longint induced_term(longint c, longint s, longint unsigned g,
                                            longint unsigned d);
        longint unsigned num;
        longint unsigned mag;
        num = longint'(c < 0 ? -c : c) * longint'(s < 0 ? -s : s);
        mag = (num * g) / (d * 64'd102944);
        return ((c < 0) != (s < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic vel_t velocity_at(logic signed [15:0] px, logic signed [15:0] py);
        longint          vx;
        longint          vy;
        longint          rx;
        longint          ry;
        longint unsigned r2;
        longint unsigned g;
        longint unsigned d;
        longint unsigned s2;
        int              n;
        vel_t            v;
        vx = 0;
        vy = 0;
        n  = (count_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(count_reg);
        s2 = (sigma_reg == 0) ? 1 : longint'(sigma_reg);
        for (int i = 0; i < n; i++)
        begin
            rx = longint'(px) - longint'(part_x[i]);
            ry = longint'(py) - longint'(part_y[i]);
            r2 = rx * rx + ry * ry;
            // a particle right on the query point adds nothing
            if (r2 == 0)
                continue;
            g  = kernel_gain(r2, s2);
            d  = (r2 > 268) ? r2 : 268;
            vx = vx + induced_term(ry, longint'(part_s[i]), g, d);
            vy = vy - induced_term(rx, longint'(part_s[i]), g, d);
        end
        v.saturated = 1'b0;
        if (vx > 64'sd2147483647)       begin vx = 64'sd2147483647;  v.saturated = 1'b1; end
        else if (vx < -64'sd2147483648) begin vx = -64'sd2147483648; v.saturated = 1'b1; end
        if (vy > 64'sd2147483647)       begin vy = 64'sd2147483647;  v.saturated = 1'b1; end
        else if (vy < -64'sd2147483648) begin vy = -64'sd2147483648; v.saturated = 1'b1; end
        v.vel_x = vx[31:0];
        v.vel_y = vy[31:0];
        return v;
    endfunction

    // driver: feeds the input channel from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        bit    hold_item;
        if (!rst_n)
        begin
            in_bus.valid     <= 1'b0;
            in_bus.operation <= 1'b0;
            in_bus.index     <= '0;
            in_bus.pos_x     <= '0;
            in_bus.pos_y     <= '0;
            in_bus.strength  <= '0;
            in_gap = 0;
        end
        else
        begin
            hold_item = in_bus.valid && !in_bus.ready;
            if (in_bus.valid && in_bus.ready)
            begin
                // accepted transaction goes through the predictor
                if (in_bus.operation == OP_LOAD)
                begin
                    part_x[in_bus.index] = in_bus.pos_x;
                    part_y[in_bus.index] = in_bus.pos_y;
                    part_s[in_bus.index] = in_bus.strength;
                end
                else
                    expected_vel.push_back(velocity_at(in_bus.pos_x, in_bus.pos_y));
            end
            if (!hold_item)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 11) == 0)
                begin
                    in_gap = $urandom_range(1, 18) - 1;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.operation <= it.op;
                    in_bus.index     <= it.index;
                    in_bus.pos_x     <= it.pos_x;
                    in_bus.pos_y     <= it.pos_y;
                    in_bus.strength  <= it.strength;
                end
                else
                    in_bus.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: ready bursts and result checking
    always @(posedge clk or negedge rst_n)
    begin
        vel_t want;
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_vel.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result vel_x=%0d vel_y=%0d sat=%0b",
                                 out_bus.vel_x, out_bus.vel_y, out_bus.saturated);
                end
                else
                begin
                    want = expected_vel.pop_front();
                    if (out_bus.vel_x !== want.vel_x || out_bus.vel_y !== want.vel_y ||
                        out_bus.saturated !== want.saturated)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: expected %0d %0d sat %0b, got %0d %0d sat %0b",
                                     want.vel_x, want.vel_y, want.saturated,
                                     out_bus.vel_x, out_bus.vel_y, out_bus.saturated);
                    end
                end
            end
            if (hold_left > 1 || hold_start)
                out_bus.ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_bus.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(1, 18) - 1;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_vortex_particle_velocity_sum NOT OK");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        if (which == CFG_PARTICLE_COUNT)
            count_reg = value[CNT_W-1:0];
        else
            sigma_reg = value[SIG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_load(int idx, int x, int y, int s);
        item_t it;
        it.op       = OP_LOAD;
        it.index    = idx[IDX_W-1:0];
        it.pos_x    = x[15:0];
        it.pos_y    = y[15:0];
        it.strength = s[15:0];
        written[idx] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic push_query(int x, int y);
        item_t it;
        it.op       = OP_QUERY;
        it.index    = IDX_W'($urandom());
        it.pos_x    = x[15:0];
        it.pos_y    = y[15:0];
        it.strength = 16'($urandom());
        pending_items.push_back(it);
    endtask

    // wait for every transaction and result, then let loads drain
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_bus.valid || expected_vel.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < NUM_ENTRIES && written[n])
            n++;
        return n;
    endfunction

    initial
    begin
        int n;
        int pick;
        int cnt;
        int sel;
        errors     = 0;
        cycles     = 0;
        quiet      = 1'b0;
        hold_start = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PARTICLE_COUNT;
        cfg_data   = '0;
        count_reg  = '0;
        sigma_reg  = SIGMA_SQ_RST;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            written[i] = 1'b0;
            part_x[i]  = '0;
            part_y[i]  = '0;
            part_s[i]  = '0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty sum under reset settings
        push_query(0, 0);
        // extreme particles and a duplicate-point query
        push_load(0, -32768, -32768, 32767);
        push_load(1, 32767, 32767, -32768);
        push_load(2, 0, 0, 4096);
        push_load(3, 1, 0, -1);
        wait_idle();
        write_reg(CFG_PARTICLE_COUNT, 4);
        push_query(0, 0);            // sits on entry 2, below eps next to entry 3
        push_query(32767, -32768);   // far corner, kernel fully saturated
        push_query(-32768, 32767);
        push_query(16, -5);
        wait_idle();
        write_reg(CFG_SIGMA_SQ, 0);  // zero core size behaves as one
        push_query(3, 7);
        push_query(0, 0);
        wait_idle();
        write_reg(CFG_SIGMA_SQ, 20'hFFFFF);
        push_query(100, -200);
        push_query(-32768, -32768);
        wait_idle();

        // stacked particles drive the sum into saturation
        write_reg(CFG_SIGMA_SQ, 1);
        for (int i = 0; i < 64; i++)
            push_load(i, 0, 0, (i < 32) ? 32767 : 32767);
        wait_idle();
        write_reg(CFG_PARTICLE_COUNT, 64);
        push_query(0, 32);
        push_query(32, 0);
        wait_idle();
        for (int i = 0; i < 64; i++)
            push_load(i, 0, 0, -32768);
        push_query(-32, 0);
        wait_idle();

        // random phases with small counts
        for (int ph = 0; ph < 10; ph++)
        begin
            n = written_prefix();
            sel = $urandom_range(0, 5);
            case (sel)
                0: write_reg(CFG_SIGMA_SQ, 1);
                1: write_reg(CFG_SIGMA_SQ, 20'hFFFFF);
                2: write_reg(CFG_SIGMA_SQ, CFG_W'($urandom_range(1, 20000)));
                default: write_reg(CFG_SIGMA_SQ, CFG_W'($urandom()));
            endcase
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 6);
            if (cnt > n)
                cnt = n;
            write_reg(CFG_PARTICLE_COUNT, CFG_W'(cnt));
            if (ph == 5)
            begin
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            for (int k = 0; k < 40; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_load($urandom_range(0, 63), $urandom(), $urandom(), $urandom());
                    else
                        push_load($urandom_range(0, 63), $urandom_range(0, 2000) - 1000,
                                  $urandom_range(0, 2000) - 1000, $urandom());
                end
                else if ($urandom_range(0, 3) == 0)
                    push_query($urandom(), $urandom());
                else
                begin
                    // point near a stored particle reaches the kernel's curved region
                    pick = $urandom_range(0, (cnt > 0) ? cnt - 1 : 0);
                    push_query(int'(part_x[pick]) + $urandom_range(0, 64) - 32,
                               int'(part_y[pick]) + $urandom_range(0, 64) - 32);
                end
            end
            wait_idle();
        end

        // last part: no idling, back to back loads and queries over fresh entries
        quiet = 1'b1;
        for (int i = 0; i < 32; i++)
            push_load(i, $urandom(), $urandom(), $urandom());
        wait_idle();
        write_reg(CFG_PARTICLE_COUNT, 32);
        write_reg(CFG_SIGMA_SQ, SIGMA_SQ_RST);
        push_query($urandom(), $urandom());
        push_query($urandom(), $urandom());
        wait_idle();
        write_reg(CFG_PARTICLE_COUNT, 2);
        push_query(0, 0);
        wait_idle();

        if (errors == 0)
            $display("tb_vortex_particle_velocity_sum OK");
        else
            $display("tb_vortex_particle_velocity_sum NOT OK");
        $finish;
    end

endmodule
